// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define PTC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// An antecedent that implies a consequent sequence.
`define PTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("%m: implication violated");

`endif

// ===== rtl/ptc_pkg.sv =====
// Shared types, constants and helper functions of the compensation block.
`timescale 1ns / 1ps
package ptc_pkg;

    localparam int RAW_W     = 20;
    localparam int WORD_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int ADDR_W    = 5;
    localparam int DIV_STAGES = 64;

    localparam logic [WIDE_W-1:0] FINE_OFFSET = 64'd128000;
    localparam logic [WIDE_W-1:0] P_BASE      = 64'd1048576;
    localparam logic [WIDE_W-1:0] PRESS_SCALE = 64'd3125;
    localparam logic [WIDE_W-1:0] HALF_RANGE  = 64'd1 << 47;
    localparam int P4_SHIFT  = 35;
    localparam int P1_SHIFT  = 33;
    localparam int P5_SHIFT  = 17;
    localparam int P2_SHIFT  = 12;
    localparam int NUM_SHIFT = 31;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_TEMP_CAL   = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_HIGH = 2'd2,
        REG_COEFF_NINE = 2'd3
    } reg_idx_t;

    // Per-transaction data that travels alongside the arithmetic.
    typedef struct packed {
        logic [RAW_W-1:0]  raw_p;
        logic [WORD_W-1:0] centi;
        logic [WORD_W-1:0] fine;
        logic              invalid;
    } ctx_t;

    // Sign-extend a 16-bit calibration word to 64 bits.
    function automatic logic [WIDE_W-1:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Arithmetic right shifts.
    function automatic logic [WORD_W-1:0] asr32(input logic [WORD_W-1:0] x, input int n);
        return WORD_W'($signed(x) >>> n);
    endfunction

    function automatic logic [WIDE_W-1:0] asr64(input logic [WIDE_W-1:0] x, input int n);
        return WIDE_W'($signed(x) >>> n);
    endfunction

endpackage

// ===== rtl/pressure_temperature_compensation.sv =====
// Top level of the pressure and temperature compensation block.
//
// Usage: load the calibration words through the APB-style port (byte
// addresses 0x00 temperature words, 0x08 low pressure words, 0x10 high
// pressure words, 0x18 coefficient P9). Then present a reading pair on
// raw_pressure and raw_temperature with start high; a transaction is taken
// at every rising edge with start high, as busy never rises.
// The result is on the result ports with result_valid high for one cycle.
// Throughput: one transaction per cycle. The depth is set by the signed
// divider (64 steps, one quotient bit per step) and the other pipeline stages.
// Reset clears every calibration register to zero and drops all readings in
// flight. The receiver cannot stall: each result shows for one cycle only.
// A zero pressure divisor gives pressure 0 with pressure_invalid high.
`timescale 1ns / 1ps
module pressure_temperature_compensation (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ptc_pkg::RAW_W-1:0]   raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]   raw_temperature,
    output logic                        result_valid,
    output logic signed [31:0]          temperature_centi,
    output logic signed [31:0]          fine_temperature,
    output logic [31:0]                 pressure_q24_8,
    output logic                        pressure_invalid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptc_pkg::WIDE_W-1:0]  pwdata,
    output logic [ptc_pkg::WIDE_W-1:0]  prdata,
    output logic                        pready
);
    import ptc_pkg::*;

    logic [47:0]       temp_cal_reg;
    logic [WIDE_W-1:0] press_low_reg;
    logic [WIDE_W-1:0] press_high_reg;
    logic [15:0]       coeff_nine_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    logic              temp_valid, front_valid, div_valid, back_valid;
    ctx_t              temp_ctx, front_ctx, div_ctx, back_ctx;
    logic [WIDE_W-1:0] num, den, quo;
    logic [WORD_W-1:0] press;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign reg_idx   = reg_idx_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Calibration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            coeff_nine_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_TEMP_CAL:   temp_cal_reg   <= pwdata[47:0];
                REG_PRESS_LOW:  press_low_reg  <= pwdata;
                REG_PRESS_HIGH: press_high_reg <= pwdata;
                REG_COEFF_NINE: coeff_nine_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            REG_TEMP_CAL:   prdata = {16'b0, temp_cal_reg};
            REG_PRESS_LOW:  prdata = press_low_reg;
            REG_PRESS_HIGH: prdata = press_high_reg;
            REG_COEFF_NINE: prdata = {48'b0, coeff_nine_reg};
            default:        prdata = '0;
        endcase
    end

    // Datapath: temperature, pressure front end, divider, back end.
    ptc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .raw_p     (raw_pressure),
        .raw_t     (raw_temperature),
        .temp_cal  (temp_cal_reg),
        .out_valid (temp_valid),
        .out_ctx   (temp_ctx)
    );

    ptc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (temp_valid),
        .in_ctx     (temp_ctx),
        .press_low  (press_low_reg),
        .press_high (press_high_reg),
        .out_valid  (front_valid),
        .out_ctx    (front_ctx),
        .num        (num),
        .den        (den)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ctx    (front_ctx),
        .num       (num),
        .den       (den),
        .out_valid (div_valid),
        .out_ctx   (div_ctx),
        .quo       (quo)
    );

    ptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ctx     (div_ctx),
        .quo        (quo),
        .press_high (press_high_reg),
        .coeff_nine (coeff_nine_reg),
        .out_valid  (back_valid),
        .out_ctx    (back_ctx),
        .press      (press)
    );

    assign result_valid      = back_valid;
    assign temperature_centi = $signed(back_ctx.centi);
    assign fine_temperature  = $signed(back_ctx.fine);
    assign pressure_q24_8    = press;
    assign pressure_invalid  = back_ctx.invalid;
endmodule

// ===== rtl/ptc_mul64.sv =====
// Two-stage 64-bit multiplier that keeps the low 64 bits of the product.
`timescale 1ns / 1ps
module ptc_mul64 (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] y
);
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] y_reg;

    // First stage: 32x32 partial products; the high-by-high term drops out.
    always_ff @(posedge clk)
    begin
        ll_reg <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
        lh_reg <= a[31:0] * b[63:32];
        hl_reg <= a[63:32] * b[31:0];
    end

    // Second stage: combine the partial products.
    always_ff @(posedge clk)
    begin
        y_reg <= ll_reg + {lh_reg + hl_reg, 32'b0};
    end

    assign y = y_reg;
endmodule

// ===== rtl/ptc_temp.sv =====
// Temperature polynomial pipeline: five stages from raw reading to fine value.
`timescale 1ns / 1ps
module ptc_temp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [ptc_pkg::RAW_W-1:0]  raw_p,
    input  logic [ptc_pkg::RAW_W-1:0]  raw_t,
    input  logic [47:0]                temp_cal,
    output logic                       out_valid,
    output ptc_pkg::ctx_t              out_ctx
);
    import ptc_pkg::*;

    logic [WORD_W-1:0] t1, t2, t3;
    logic [4:0]        vld_reg;
    logic [RAW_W-1:0]  rp_reg [0:3];
    logic [WORD_W-1:0] diff_reg, dlt_reg;
    logic [WORD_W-1:0] pa_reg, dd_reg;
    logic [WORD_W-1:0] a_reg, b1_reg;
    logic [WORD_W-1:0] fine_reg;
    logic [WORD_W-1:0] scaled;
    ctx_t              ctx_reg;

    assign t1 = {16'b0, temp_cal[15:0]};
    assign t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    assign t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Raw pressure rides along for the later stages.
    always_ff @(posedge clk)
    begin
        rp_reg[0] <= raw_p;
        for (int i = 1; i < 4; i++)
        begin
            rp_reg[i] <= rp_reg[i-1];
        end
    end

    // Offset terms, products, scaling and the fine sum, one step per stage.
    always_ff @(posedge clk)
    begin
        diff_reg <= {15'b0, raw_t[19:3]} - {t1[30:0], 1'b0};
        dlt_reg  <= {16'b0, raw_t[19:4]} - t1;
        pa_reg   <= diff_reg * t2;
        dd_reg   <= dlt_reg * dlt_reg;
        a_reg    <= asr32(pa_reg, 11);
        b1_reg   <= asr32(dd_reg, 12) * t3;
        fine_reg <= a_reg + asr32(b1_reg, 14);
    end

    // Hundredths of a degree: (fine * 5 + 128) >> 8.
    assign scaled = {fine_reg[29:0], 2'b0} + fine_reg + 32'd128;

    always_ff @(posedge clk)
    begin
        ctx_reg.raw_p   <= rp_reg[3];
        ctx_reg.fine    <= fine_reg;
        ctx_reg.centi   <= asr32(scaled, 8);
        ctx_reg.invalid <= 1'b0;
    end

    assign out_valid = vld_reg[4];
    assign out_ctx   = ctx_reg;
endmodule

// ===== rtl/ptc_front.sv =====
// Pressure front end: builds the division numerator and divisor in ten stages.
`timescale 1ns / 1ps
module ptc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ptc_pkg::ctx_t              in_ctx,
    input  logic [ptc_pkg::WIDE_W-1:0] press_low,
    input  logic [ptc_pkg::WIDE_W-1:0] press_high,
    output logic                       out_valid,
    output ptc_pkg::ctx_t              out_ctx,
    output logic [ptc_pkg::WIDE_W-1:0] num,
    output logic [ptc_pkg::WIDE_W-1:0] den
);
    import ptc_pkg::*;

    localparam int DEPTH = 10;

    logic [WIDE_W-1:0] p1, p2, p3, p4, p5, p6;
    logic [DEPTH-1:0]  vld_reg;
    ctx_t              ctx_reg [0:DEPTH-1];
    logic [WIDE_W-1:0] v1_reg;
    logic [WIDE_W-1:0] sq, m5, m2, m6, m3, m1, mn;
    logic [WIDE_W-1:0] m5_dly_reg [0:1];
    logic [WIDE_W-1:0] m2_dly_reg [0:1];
    logic [WIDE_W-1:0] v2_reg, v1b_reg;
    logic [WIDE_W-1:0] xs_reg, nb_reg;
    logic [WIDE_W-1:0] num_reg, den_reg;

    assign p1 = {48'b0, press_low[15:0]};
    assign p2 = sx16(press_low[31:16]);
    assign p3 = sx16(press_low[47:32]);
    assign p4 = sx16(press_low[63:48]);
    assign p5 = sx16(press_high[15:0]);
    assign p6 = sx16(press_high[31:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= in_ctx;
        for (int i = 1; i < DEPTH; i++)
        begin
            ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    // Stage 0: centered fine temperature.
    always_ff @(posedge clk)
    begin
        v1_reg <= {{32{in_ctx.fine[31]}}, in_ctx.fine} - FINE_OFFSET;
    end

    // Stages 1-2: square and linear products.
    ptc_mul64 u_mul_sq (.clk(clk), .a(v1_reg), .b(v1_reg), .y(sq));
    ptc_mul64 u_mul_p5 (.clk(clk), .a(v1_reg), .b(p5),     .y(m5));
    ptc_mul64 u_mul_p2 (.clk(clk), .a(v1_reg), .b(p2),     .y(m2));

    // Stages 3-4: square terms, with the linear terms held alongside.
    ptc_mul64 u_mul_p6 (.clk(clk), .a(sq), .b(p6), .y(m6));
    ptc_mul64 u_mul_p3 (.clk(clk), .a(sq), .b(p3), .y(m3));

    always_ff @(posedge clk)
    begin
        m5_dly_reg[0] <= m5;
        m5_dly_reg[1] <= m5_dly_reg[0];
        m2_dly_reg[0] <= m2;
        m2_dly_reg[1] <= m2_dly_reg[0];
    end

    // Stage 5: sum the polynomial terms.
    always_ff @(posedge clk)
    begin
        v2_reg  <= m6 + (m5_dly_reg[1] << P5_SHIFT) + (p4 << P4_SHIFT);
        v1b_reg <= asr64(m3, 8) + (m2_dly_reg[1] << P2_SHIFT);
    end

    // Stage 6: operands of the divisor and numerator products.
    always_ff @(posedge clk)
    begin
        xs_reg <= HALF_RANGE + v1b_reg;
        nb_reg <= ((P_BASE - {44'b0, ctx_reg[5].raw_p}) << NUM_SHIFT) - v2_reg;
    end

    // Stages 7-8: scale by P1 and by the fixed factor.
    ptc_mul64 u_mul_p1 (.clk(clk), .a(xs_reg), .b(p1),          .y(m1));
    ptc_mul64 u_mul_sc (.clk(clk), .a(nb_reg), .b(PRESS_SCALE), .y(mn));

    // Stage 9: final divisor and numerator.
    always_ff @(posedge clk)
    begin
        den_reg <= asr64(m1, P1_SHIFT);
        num_reg <= mn;
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_ctx   = ctx_reg[DEPTH-1];
    assign num       = num_reg;
    assign den       = den_reg;
endmodule

// ===== rtl/ptc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
`timescale 1ns / 1ps
module ptc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ptc_pkg::ctx_t              in_ctx,
    input  logic [ptc_pkg::WIDE_W-1:0] num,
    input  logic [ptc_pkg::WIDE_W-1:0] den,
    output logic                       out_valid,
    output ptc_pkg::ctx_t              out_ctx,
    output logic [ptc_pkg::WIDE_W-1:0] quo
);
    import ptc_pkg::*;

    logic [DIV_STAGES+1:0] vld_reg;
    logic [WIDE_W-1:0]     rem_reg [0:DIV_STAGES];
    logic [WIDE_W-1:0]     dq_reg  [0:DIV_STAGES];
    logic [WIDE_W-1:0]     dv_reg  [0:DIV_STAGES];
    logic                  neg_reg [0:DIV_STAGES];
    ctx_t                  ctx_reg [0:DIV_STAGES];
    logic [WIDE_W-1:0]     quo_reg;
    ctx_t                  out_ctx_reg;
    ctx_t                  entry_ctx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STAGES:0], in_valid};
        end
    end

    // Incoming context with the zero-divisor flag filled in.
    always_comb
    begin
        entry_ctx         = in_ctx;
        entry_ctx.invalid = (den == '0);
    end

    // Entry stage: magnitudes, quotient sign and the zero-divisor flag.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        dq_reg[0]  <= num[63] ? (64'd0 - num) : num;
        dv_reg[0]  <= den[63] ? (64'd0 - den) : den;
        neg_reg[0] <= num[63] ^ den[63];
        ctx_reg[0] <= entry_ctx;
    end

    // Restoring steps: shift in one dividend bit, subtract when it fits.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        logic [WIDE_W:0] shifted;
        logic [WIDE_W:0] trial;
        logic            fits;

        always_comb
        begin
            shifted = {rem_reg[k], dq_reg[k][WIDE_W-1]};
            trial   = shifted - {1'b0, dv_reg[k]};
            fits    = (shifted >= {1'b0, dv_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= fits ? trial[WIDE_W-1:0] : shifted[WIDE_W-1:0];
            dq_reg[k+1]  <= {dq_reg[k][WIDE_W-2:0], fits};
            dv_reg[k+1]  <= dv_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ctx_reg[k+1] <= ctx_reg[k];
        end
    end

    // Exit stage: apply the quotient sign.
    always_ff @(posedge clk)
    begin
        quo_reg     <= neg_reg[DIV_STAGES] ? (64'd0 - dq_reg[DIV_STAGES])
                                           : dq_reg[DIV_STAGES];
        out_ctx_reg <= ctx_reg[DIV_STAGES];
    end

    assign out_valid = vld_reg[DIV_STAGES+1];
    assign out_ctx   = out_ctx_reg;
    assign quo       = quo_reg;
endmodule

// ===== rtl/ptc_back.sv =====
// Pressure back end: P7..P9 correction of the quotient in seven stages.
`timescale 1ns / 1ps
module ptc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ptc_pkg::ctx_t              in_ctx,
    input  logic [ptc_pkg::WIDE_W-1:0] quo,
    input  logic [ptc_pkg::WIDE_W-1:0] press_high,
    input  logic [15:0]                coeff_nine,
    output logic                       out_valid,
    output ptc_pkg::ctx_t              out_ctx,
    output logic [ptc_pkg::WORD_W-1:0] press
);
    import ptc_pkg::*;

    localparam int DEPTH = 7;

    logic [WIDE_W-1:0] p7, p8, p9;
    logic [DEPTH-1:0]  vld_reg;
    ctx_t              ctx_reg [0:DEPTH-1];
    logic [WIDE_W-1:0] p_reg, ps_reg;
    logic [WIDE_W-1:0] p_dly_reg  [0:3];
    logic [WIDE_W-1:0] ps_dly_reg [0:1];
    logic [WIDE_W-1:0] m8_dly_reg [0:1];
    logic [WIDE_W-1:0] m9, m8, w1;
    logic [WIDE_W-1:0] sum_reg;
    logic [WIDE_W-1:0] final_sum;
    logic [WORD_W-1:0] press_reg;

    assign p7 = sx16(press_high[47:32]);
    assign p8 = sx16(press_high[63:48]);
    assign p9 = sx16(coeff_nine);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= in_ctx;
        for (int i = 1; i < DEPTH; i++)
        begin
            ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    // Stage 0: quotient and its scaled-down copy.
    always_ff @(posedge clk)
    begin
        p_reg  <= quo;
        ps_reg <= asr64(quo, 13);
    end

    // Stages 1-2: first products, with operands held for later use.
    ptc_mul64 u_mul_p9 (.clk(clk), .a(p9), .b(ps_reg), .y(m9));
    ptc_mul64 u_mul_p8 (.clk(clk), .a(p8), .b(p_reg),  .y(m8));

    always_ff @(posedge clk)
    begin
        p_dly_reg[0]  <= p_reg;
        for (int i = 1; i < 4; i++)
        begin
            p_dly_reg[i] <= p_dly_reg[i-1];
        end
        ps_dly_reg[0] <= ps_reg;
        ps_dly_reg[1] <= ps_dly_reg[0];
        m8_dly_reg[0] <= m8;
        m8_dly_reg[1] <= m8_dly_reg[0];
    end

    // Stages 3-4: second factor of the quadratic term.
    ptc_mul64 u_mul_sq (.clk(clk), .a(m9), .b(ps_dly_reg[1]), .y(w1));

    // Stage 5: sum of the corrections.
    always_ff @(posedge clk)
    begin
        sum_reg <= p_dly_reg[3] + asr64(w1, 25) + asr64(m8_dly_reg[1], 19);
    end

    // Stage 6: final offset, zero when the divisor was zero.
    assign final_sum = asr64(sum_reg, 8) + (p7 << 4);

    always_ff @(posedge clk)
    begin
        press_reg <= ctx_reg[5].invalid ? '0 : final_sum[WORD_W-1:0];
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_ctx   = ctx_reg[DEPTH-1];
    assign press     = press_reg;
endmodule

// ===== rtl/ptc_checker.sv =====
// Port-level checker of the compensation block and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptc_props (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [31:0] pressure_q24_8,
    input logic        pressure_invalid
);
    // The pipeline never refuses a transaction.
    `PTC_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    // Every accepted transaction yields a result.
    `PTC_ASSERT_IMPLY(a_latency_fwd, clk, rst_n, start && !busy, ##88 result_valid)
    // No result appears without a matching accepted transaction before it.
    `PTC_ASSERT_IMPLY(a_latency_back, clk, rst_n, result_valid, $past(start && !busy, 88))
    // An invalid pressure result reads as zero.
    `PTC_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, result_valid && pressure_invalid, pressure_q24_8 == '0)
endmodule

bind pressure_temperature_compensation ptc_props u_ptc_props (.*);

// ===== sim/ptc_checker.sv =====
// Checker of the compensation block: tracks the calibration, predicts and compares results.
`timescale 1ns / 1ps
module ptc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature,
    input  logic                       result_valid,
    input  logic [31:0]                temperature_centi,
    input  logic [31:0]                fine_temperature,
    input  logic [31:0]                pressure_q24_8,
    input  logic                       pressure_invalid,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [ptc_pkg::ADDR_W-1:0] paddr,
    input  logic [ptc_pkg::WIDE_W-1:0] pwdata,
    output int                         mismatches,
    output int                         outstanding
);
    import ptc_pkg::*;

    typedef struct {
        logic [31:0] centi;
        logic [31:0] fine;
        logic [31:0] press;
        logic        invalid;
    } reading_t;

    // Calibration as the block should hold it.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_p9;

    reading_t expected_readings[$];

    assign outstanding = expected_readings.size();

    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        sra32 = $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
        sra64 = $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] ext16(input logic [15:0] v);
        ext16 = {{48{v[15]}}, v};
    endfunction

    // Truncating signed division; the most negative value over -1 wraps.
    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        div_trunc = (a[63] != b[63]) ? -q : q;
    endfunction

    // Integer compensation polynomials for one reading pair.
    function automatic reading_t compensate(input logic [19:0] rp, input logic [19:0] rt);
        reading_t r;
        logic [31:0] adc_t, t1, t2, t3, a, d, b, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] f64, v1, v2, p, ps, w1, w2;
        adc_t = {12'd0, rt};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        a = sra32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d = (adc_t >> 4) - t1;
        b = sra32(sra32(d * d, 12) * t3, 14);
        fine = a + b;
        r.fine = fine;
        r.centi = sra32(fine * 32'd5 + 32'd128, 8);

        p1 = {48'd0, cal_press_lo[15:0]};
        p2 = ext16(cal_press_lo[31:16]);
        p3 = ext16(cal_press_lo[47:32]);
        p4 = ext16(cal_press_lo[63:48]);
        p5 = ext16(cal_press_hi[15:0]);
        p6 = ext16(cal_press_hi[31:16]);
        p7 = ext16(cal_press_hi[47:32]);
        p8 = ext16(cal_press_hi[63:48]);
        p9 = ext16(cal_p9);

        f64 = {{32{fine[31]}}, fine};
        v1 = f64 - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);

        // A zero divisor gives no pressure and raises the invalid flag.
        if (v1 == 64'd0) begin
            r.press = 32'd0;
            r.invalid = 1'b1;
        end
        else begin
            p = 64'd1048576 - {44'd0, rp};
            p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
            ps = sra64(p, 13);
            w1 = sra64(p9 * ps * ps, 25);
            w2 = sra64(p8 * p, 19);
            p = sra64(p + w1 + w2, 8) + (p7 << 4);
            r.press = p[31:0];
            r.invalid = 1'b0;
        end
        return r;
    endfunction

    // Follow register writes, queue a prediction per accepted transaction,
    // and compare each result with the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        reading_t e;
        if (!rst_n) begin
            cal_temp <= '0;
            cal_press_lo <= '0;
            cal_press_hi <= '0;
            cal_p9 <= '0;
            expected_readings.delete();
            mismatches <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:3]))
                    REG_TEMP_CAL:   cal_temp <= pwdata[47:0];
                    REG_PRESS_LOW:  cal_press_lo <= pwdata;
                    REG_PRESS_HIGH: cal_press_hi <= pwdata;
                    REG_COEFF_NINE: cal_p9 <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_readings.push_back(compensate(raw_pressure, raw_temperature));
            if (result_valid) begin
                if (expected_readings.size() == 0) begin
                    if (mismatches < 10)
                        $display("Unexpected result: centi %h fine %h press %h inv %b",
                                 temperature_centi, fine_temperature, pressure_q24_8,
                                 pressure_invalid);
                    mismatches <= mismatches + 1;
                end
                else begin
                    e = expected_readings.pop_front();
                    if (e.centi !== temperature_centi || e.fine !== fine_temperature ||
                        e.press !== pressure_q24_8 || e.invalid !== pressure_invalid) begin
                        if (mismatches < 10)
                            $display("Mismatch: expected centi %h fine %h press %h inv %b, got centi %h fine %h press %h inv %b",
                                     e.centi, e.fine, e.press, e.invalid,
                                     temperature_centi, fine_temperature, pressure_q24_8,
                                     pressure_invalid);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_pressure_temperature_compensation.sv =====
// Testbench top of the compensation block: stimulus, calibration phases and verdict.
`timescale 1ns / 1ps
module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic        result_valid;
    logic [31:0] temperature_centi;
    logic [31:0] fine_temperature;
    logic [31:0] pressure_q24_8;
    logic        pressure_invalid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          cycles;
    logic        busy_at_fall;
    int          idle_pct;

    pressure_temperature_compensation uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
        .result_valid(result_valid), .temperature_centi(temperature_centi),
        .fine_temperature(fine_temperature), .pressure_q24_8(pressure_q24_8),
        .pressure_invalid(pressure_invalid), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    ptc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
        .result_valid(result_valid), .temperature_centi(temperature_centi),
        .fine_temperature(fine_temperature), .pressure_q24_8(pressure_q24_8),
        .pressure_invalid(pressure_invalid), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Busy as it stood before the next rising edge.
    always @(negedge clk)
    begin
        busy_at_fall = busy;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Register write on the configuration port: setup phase, then access phase.
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Load a full calibration set from twelve words.
    task automatic load_calibration(input logic [15:0] w[12]);
        write_reg(REG_TEMP_CAL, {16'd0, w[2], w[1], w[0]});
        write_reg(REG_PRESS_LOW, {w[6], w[5], w[4], w[3]});
        write_reg(REG_PRESS_HIGH, {w[10], w[9], w[8], w[7]});
        write_reg(REG_COEFF_NINE, {48'd0, w[11]});
    endtask

    // One reading pair; start stays high into the next transaction unless idling.
    // Each following cycle idles with the idle percentage as its chance.
    task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt);
        start <= 1'b1;
        raw_pressure <= rp;
        raw_temperature <= rt;
        do @(posedge clk); while (busy_at_fall);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Lower start and hold until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic directed_readings();
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'd0);
        send_reading(20'hAAAAA, 20'h55555);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'd415148, 20'd519888);
        send_reading(20'd300000, 20'd440064);
        send_reading(20'd1, 20'd1);
        send_reading(20'h80000, 20'h80000);
    endtask

    function automatic logic [19:0] pick_raw(input int lo, input int hi);
        if ($urandom_range(99) < 70)
            return 20'($urandom_range(hi, lo));
        return 20'($urandom);
    endfunction

    initial
    begin
        logic [15:0] typical[12];
        logic [15:0] cal[12];
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        raw_pressure = '0;
        raw_temperature = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        typical = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
                    16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero calibration after reset (the divisor is zero), then the typical set.
        directed_readings();
        drain();
        load_calibration(typical);
        directed_readings();
        drain();

        // Random phases, each with its own calibration.
        for (int seg = 1; seg <= 8; seg++) begin
            idle_pct = (seg <= 3) ? 38 : (seg <= 6) ? 79 : 0;
            for (int i = 0; i < 12; i++) begin
                case (seg)
                    2, 7:    cal[i] = 16'($urandom);
                    3:       cal[i] = 16'hFFFF;
                    4:       cal[i] = 16'h7FFF;
                    5:       cal[i] = 16'h8000;
                    default: cal[i] = typical[i];
                endcase
            end
            if (seg == 6)
                cal[3] = 16'd0;
            if (seg == 8)
                cal[0] = 16'hFFFF;
            load_calibration(cal);
            for (int n = 0; n < 190; n++) begin
                send_reading(pick_raw(250000, 450000), pick_raw(400000, 600000));
                // Once per phase, hold off until the pipeline is empty.
                if (n == 95)
                    drain();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
